// ===== rtl/cfq_pkg.sv =====
// Shared request codes, status codes, controller states and control structs of the FIFO.
package cfq_pkg;

  localparam int unsigned WordWidth = 32;

  typedef enum logic [1:0] {
    REQ_ENQUEUE = 2'd0,
    REQ_DEQUEUE = 2'd1,
    REQ_DISPLAY = 2'd2,
    REQ_UNUSED  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RSVD  = 2'd3
  } status_e;

  typedef enum logic {
    S_IDLE   = 1'b0,
    S_STREAM = 1'b1
  } state_e;

  typedef struct packed {
    logic    enq_write;
    logic    rd_start_deq;
    logic    rd_start_disp;
    logic    rd_next;
    logic    out_load;
    status_e out_status;
    logic    out_from_mem;
    logic    out_last;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic out_free;
    logic rem_one;
  } stat_t;

endpackage

// ===== rtl/cfq_req_if.sv =====
// Request channel interface: valid, ready and the request payload.
interface cfq_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic signed [31:0] data_in;

  modport source (output valid, output req_type, output data_in, input ready);
  modport sink (input valid, input req_type, input data_in, output ready);
endinterface

// ===== rtl/cfq_rsp_if.sv =====
// Result channel interface: valid, ready and the result payload.
interface cfq_rsp_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] data_out;
  logic               last;

  modport source (output valid, output status, output data_out, output last, input ready);
  modport sink (input valid, input status, input data_out, input last, output ready);
endinterface

// ===== rtl/cfq_ctrl.sv =====
// Controller state machine that decodes requests and sequences reads and result beats.
module cfq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  input  logic [1:0]    req_type_i,
  input  cfq_pkg::stat_t stat_i,
  output logic          req_ready_o,
  output cfq_pkg::cmd_t cmd_o
);
  import cfq_pkg::*;

  state_e state_q, state_d;
  req_e   req;

  assign req = req_e'(req_type_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    req_ready_o = 1'b0;
    cmd_o       = '0;
    cmd_o.out_status = ST_OK;
    unique case (state_q)
      S_IDLE: begin
        req_ready_o = stat_i.out_free;
        if (req_valid_i && stat_i.out_free) begin
          unique case (req)
            REQ_ENQUEUE: begin
              cmd_o.out_load = 1'b1;
              cmd_o.out_last = 1'b1;
              if (stat_i.full) begin
                cmd_o.out_status = ST_FULL;
              end else begin
                cmd_o.enq_write = 1'b1;
              end
            end
            REQ_DEQUEUE, REQ_DISPLAY: begin
              if (stat_i.empty) begin
                cmd_o.out_load   = 1'b1;
                cmd_o.out_last   = 1'b1;
                cmd_o.out_status = ST_EMPTY;
              end else begin
                cmd_o.rd_start_deq  = (req == REQ_DEQUEUE);
                cmd_o.rd_start_disp = (req == REQ_DISPLAY);
                state_d = S_STREAM;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_STREAM: begin
        if (stat_i.out_free) begin
          cmd_o.out_load     = 1'b1;
          cmd_o.out_from_mem = 1'b1;
          cmd_o.out_last     = stat_i.rem_one;
          if (stat_i.rem_one) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.rd_next = 1'b1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/cfq_dp.sv =====
// Datapath with the entry memory, head, tail and count registers, read pointer and result register.
module cfq_dp #(
  parameter int unsigned DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic signed [31:0] data_in_i,
  input  cfq_pkg::cmd_t      cmd_i,
  input  logic               out_ready_i,
  output cfq_pkg::stat_t     stat_o,
  output logic               out_valid_o,
  output logic [1:0]         out_status_o,
  output logic signed [31:0] out_data_o,
  output logic               out_last_o
);
  import cfq_pkg::*;

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [IW-1:0] LastIdx = IW'(DEPTH - 1);
  localparam logic [CW-1:0] FullCnt = CW'(DEPTH);

  logic [WordWidth-1:0] mem_q [DEPTH];
  logic [WordWidth-1:0] rd_data_q;
  logic [IW-1:0]        head_q, head_d, tail_q, tail_d, ptr_q, ptr_d, rd_addr;
  logic [CW-1:0]        cnt_q, cnt_d, rem_q, rem_d;
  logic                 rd_en;
  logic                 out_valid_q, out_valid_d;
  status_e              out_status_q;
  logic [WordWidth-1:0] out_data_q;
  logic                 out_last_q;

  function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] idx);
    wrap_inc = (idx == LastIdx) ? '0 : idx + IW'(1);
  endfunction

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    cnt_d   = cnt_q;
    ptr_d   = ptr_q;
    rem_d   = rem_q;
    rd_addr = head_q;
    rd_en   = 1'b0;
    if (cmd_i.enq_write) begin
      tail_d = wrap_inc(tail_q);
      cnt_d  = cnt_q + CW'(1);
    end
    if (cmd_i.rd_start_deq) begin
      rd_en  = 1'b1;
      ptr_d  = head_q;
      rem_d  = CW'(1);
      head_d = wrap_inc(head_q);
      cnt_d  = cnt_q - CW'(1);
    end
    if (cmd_i.rd_start_disp) begin
      rd_en = 1'b1;
      ptr_d = head_q;
      rem_d = cnt_q;
    end
    if (cmd_i.rd_next) begin
      rd_en   = 1'b1;
      rd_addr = wrap_inc(ptr_q);
      ptr_d   = rd_addr;
      rem_d   = rem_q - CW'(1);
    end
    out_valid_d = out_valid_q;
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      cnt_q       <= '0;
      ptr_q       <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      head_q      <= head_d;
      tail_q      <= tail_d;
      cnt_q       <= cnt_d;
      ptr_q       <= ptr_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.enq_write) begin
      mem_q[tail_q] <= data_in_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_status_q <= cmd_i.out_status;
      out_data_q   <= cmd_i.out_from_mem ? rd_data_q : '0;
      out_last_q   <= cmd_i.out_last;
    end
  end

  assign stat_o.full     = (cnt_q == FullCnt);
  assign stat_o.empty    = (cnt_q == '0);
  assign stat_o.out_free = !out_valid_q || out_ready_i;
  assign stat_o.rem_one  = (rem_q == CW'(1));

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_data_o   = out_data_q;
  assign out_last_o   = out_last_q;

endmodule

// ===== rtl/circular_fifo_queue.sv =====
// Top level of the circular FIFO queue of signed 32-bit words.
// The block takes requests on req_i and returns result beats on rsp_o, both
// valid/ready channels. A request is an enqueue, a dequeue or a display of
// all stored words; request code 3 is dropped and gives no beat.
// Every beat of a request except the final one has last low.
// Enqueue and every empty or full answer are registered in the accept cycle
// and appear in the next one; such requests are taken one per cycle while
// the receiver keeps up. A dequeue needs one memory read: its word passes
// the registered read port, then the result register, and the next request
// is taken once that beat is loaded. A display streams the stored words
// head to tail at one beat per cycle while the receiver keeps up, paced by
// the read port, and holds off new requests until the last beat is loaded.
// Reset empties the queue at once; the stored words need no clearing.
// When the receiver stalls, the result register holds its beat and no new
// request or stream step proceeds until that beat is taken.
module circular_fifo_queue #(
  parameter int unsigned DEPTH = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  cfq_req_if.sink   req_i,
  cfq_rsp_if.source rsp_o
);
  import cfq_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic  ready;

  cfq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_type_i  (req_i.req_type),
    .stat_i      (stat),
    .req_ready_o (ready),
    .cmd_o       (cmd)
  );

  cfq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .data_in_i    (req_i.data_in),
    .cmd_i        (cmd),
    .out_ready_i  (rsp_o.ready),
    .stat_o       (stat),
    .out_valid_o  (rsp_o.valid),
    .out_status_o (rsp_o.status),
    .out_data_o   (rsp_o.data_out),
    .out_last_o   (rsp_o.last)
  );

  assign req_i.ready = ready;

endmodule
